// ===== design/iic_pkg.sv =====
// Package for the integer instruction core: item types, status codes,
// instruction constants and the shared ALU helper functions. No dependencies.
package iic_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] word_address;
    logic [31:0] word_data;
    logic [4:0]  register_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] next_pc;
    logic [3:0]  flags;
    logic        reg_written;
    logic [4:0]  reg_dest;
    logic [63:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_byte_address;
    logic [63:0] mem_value;
    logic        mem_wide;
  } out_item_t;

  localparam logic [1:0] OP_PRELOAD = 2'd0;
  localparam logic [1:0] OP_EXEC    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_BADENC  = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;

  localparam logic [31:0] HALT_WORD   = 32'h8A00_0000;
  localparam logic [63:0] MASK32      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [3:0]  FLAGS_RESET = 4'h4;
  localparam logic [5:0]  BR_IMM      = 6'h05;
  localparam logic [5:0]  BR_REG      = 6'h35;
  localparam logic [5:0]  BR_COND     = 6'h15;
  localparam logic [4:0]  ZERO_REG    = 5'd31;

  typedef enum logic [1:0] {
    K_PRELOAD,
    K_EXEC,
    K_READ,
    K_BAD
  } kind_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic        pre_fits;
    logic [13:0] word_address;
    logic [31:0] word_data;
    logic [4:0]  register_index;
  } q_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_REGRD,
    S_FETCH,
    S_FWAIT,
    S_DECODE,
    S_RDB,
    S_RDC,
    S_RDW,
    S_SHIFT,
    S_ALU,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MULACC,
    S_MEMWAIT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic [63:0] val;
    logic [3:0]  fl;
  } alu_res_t;

  function automatic alu_res_t add_flags(input logic [63:0] a, input logic [63:0] b,
                                         input logic sub, input logic wide);
    logic [63:0] am;
    logic [63:0] bm;
    logic [64:0] s;
    logic [63:0] r;
    logic        c;
    logic        v;
    logic        n;
    alu_res_t    o;
    am = wide ? a : (a & MASK32);
    bm = wide ? b : (b & MASK32);
    if (sub) begin
      bm = wide ? ~bm : (~bm & MASK32);
    end
    s = {1'b0, am} + {1'b0, bm} + {64'b0, sub};
    if (wide) begin
      r = s[63:0];
      c = s[64];
      v = (am[63] ^ r[63]) & (bm[63] ^ r[63]);
      n = r[63];
    end else begin
      r = {32'b0, s[31:0]};
      c = s[32];
      v = (am[31] ^ r[31]) & (bm[31] ^ r[31]);
      n = r[31];
    end
    o.val = r;
    o.fl  = {n, (r == 64'b0), c, v};
    return o;
  endfunction

  function automatic logic [63:0] shift_val(input logic [63:0] v, input logic [1:0] kind,
                                            input logic [5:0] amt, input logic wide);
    logic [31:0] v32;
    logic [31:0] r32;
    logic [63:0] r;
    v32 = v[31:0];
    if (wide) begin
      case (kind)
        2'd0:    r = v << amt;
        2'd1:    r = v >> amt;
        2'd2:    r = $unsigned($signed(v) >>> amt);
        default: r = (v >> amt) | (v << (7'd64 - {1'b0, amt}));
      endcase
    end else begin
      case (kind)
        2'd0:    r32 = v32 << amt[4:0];
        2'd1:    r32 = v32 >> amt[4:0];
        2'd2:    r32 = $unsigned($signed(v32) >>> amt[4:0]);
        default: r32 = (v32 >> amt[4:0]) | (v32 << (6'd32 - {1'b0, amt[4:0]}));
      endcase
      r = {32'b0, r32};
    end
    return r;
  endfunction

  function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] fl);
    logic t;
    case (c[3:1])
      3'd0:    t = fl[2];
      3'd1:    t = fl[1];
      3'd2:    t = fl[3];
      3'd3:    t = fl[0];
      3'd4:    t = fl[1] & ~fl[2];
      3'd5:    t = (fl[3] == fl[0]);
      3'd6:    t = (fl[3] == fl[0]) & ~fl[2];
      default: t = 1'b1;
    endcase
    if (c[0] && (c != 4'hF)) begin
      t = ~t;
    end
    return t;
  endfunction

endpackage

// ===== design/iic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/iic_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on iic_pkg.
module iic_front #(
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iic_pkg::in_item_t in_data,
  output logic              q_valid,
  output iic_pkg::q_item_t  q_item,
  input  logic              q_pop
);

  localparam logic [31:0] PRE_LIM = 32'(MEM_BYTES - 4);

  iic_pkg::q_item_t ent_r [2];
  iic_pkg::q_item_t cls;
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             push;

  // Classify the opcode and check the preload address range up front.
  always_comb begin
    case (in_data.opcode)
      iic_pkg::OP_PRELOAD: cls.kind = iic_pkg::K_PRELOAD;
      iic_pkg::OP_EXEC:    cls.kind = iic_pkg::K_EXEC;
      iic_pkg::OP_READ:    cls.kind = iic_pkg::K_READ;
      default:             cls.kind = iic_pkg::K_BAD;
    endcase
    cls.pre_fits       = ({16'b0, in_data.word_address, 2'b00} <= PRE_LIM);
    cls.word_address   = in_data.word_address;
    cls.word_data      = in_data.word_data;
    cls.register_index = in_data.register_index;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid & in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== design/iic_back.sv =====
// Back end: sequencer that executes queued items against the register file
// and the banked byte memory. Depends on iic_pkg and iic_ram.
module iic_back #(
  parameter int MEM_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  iic_pkg::q_item_t   q_item,
  output logic               q_pop,
  input  logic [14:0]        prog_words,
  output logic               res_valid,
  output iic_pkg::out_item_t res_item,
  input  logic               res_ready
);

  localparam int ROWS = MEM_BYTES / 8;
  localparam int RW   = $clog2(ROWS);
  localparam int AW   = RW + 3;
  localparam logic [63:0] LIM4 = 64'(MEM_BYTES - 4);
  localparam logic [63:0] LIM8 = 64'(MEM_BYTES - 8);

  iic_pkg::back_state_t st_r, st_nxt;
  iic_pkg::out_item_t   res_r, res_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] ir_r, ir_nxt;
  logic [63:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic [63:0] opb_r, opb_nxt, ea_r, ea_nxt, nbase_r, nbase_nxt;
  logic [63:0] p0_r, p0_nxt;
  logic [31:0] p1_r, p1_nxt, cross_r, cross_nxt;
  logic [RW-1:0] clr_r, clr_nxt;
  logic [31:0] rf_vld_r;
  logic        rf_zero_r;
  logic [2:0]  mem_lo_r;

  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [63:0] rf_wdata, rf_rdata, rfval;

  logic [63:0] mem_ea, mem_wdata, mem_got;
  logic        mem_we, mem_n8, clr_mode;
  logic [7:0]  bank_rd [8];

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Instruction fields
  logic [31:0] w;
  logic        wide;
  logic [63:0] mask;
  logic [63:0] va, vbm;
  logic        is_dpimm, is_dpreg, is_ldst, is_br;
  logic        ld_lit, ld_wb, ld_isload, nb8;

  assign w        = ir_r;
  assign wide     = w[31];
  assign mask     = wide ? 64'hFFFF_FFFF_FFFF_FFFF : iic_pkg::MASK32;
  assign va       = ra_r & mask;
  assign vbm      = rb_r & mask;
  assign is_dpimm = (w[28:26] == 3'b100);
  assign is_dpreg = (w[27:25] == 3'b101);
  assign is_ldst  = (w[28:25] == 4'b0110) || (w[28:25] == 4'b0111) || (w[28:25] == 4'b1100);
  assign is_br    = (w[28:26] == 3'b101);
  assign nb8      = w[30];
  assign ld_lit   = ~w[29];
  assign ld_wb    = w[29] & ~w[24] & ~w[21];
  assign ld_isload = ld_lit | w[22];
  assign rfval    = rf_zero_r ? 64'b0 : rf_rdata;
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    logic [63:0]        pc_p4;
    logic [63:0]        npc;
    logic [63:0]        imm;
    logic [63:0]        piece;
    logic [63:0]        keep;
    logic [63:0]        vb2;
    logic [63:0]        val;
    logic [63:0]        base_sel;
    logic [63:0]        off;
    logic [63:0]        sum;
    logic [63:0]        prod;
    logic [1:0]         stat;
    logic               wr_req;
    logic [4:0]         wr_idx;
    logic [63:0]        wr_val;
    iic_pkg::alu_res_t  ar;

    st_nxt     = st_r;
    res_nxt    = res_r;
    pc_nxt     = pc_r;
    flags_nxt  = flags_r;
    halted_nxt = halted_r;
    ir_nxt     = ir_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rc_nxt     = rc_r;
    opb_nxt    = opb_r;
    ea_nxt     = ea_r;
    nbase_nxt  = nbase_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    cross_nxt  = cross_r;
    clr_nxt    = clr_r;
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    rf_raddr   = 5'd0;
    mem_ea     = ea_r;
    mem_we     = 1'b0;
    mem_n8     = 1'b0;
    mem_wdata  = 64'b0;
    clr_mode   = 1'b0;
    mul_a      = va[31:0];
    mul_b      = vbm[31:0];
    wr_req     = 1'b0;
    wr_idx     = 5'd0;
    wr_val     = 64'b0;
    pc_p4      = pc_r + 64'd4;
    npc        = pc_p4;
    stat       = iic_pkg::ST_DONE;
    imm        = 64'b0;
    piece      = 64'b0;
    keep       = 64'b0;
    vb2        = 64'b0;
    val        = 64'b0;
    base_sel   = 64'b0;
    off        = 64'b0;
    sum        = 64'b0;
    prod       = 64'b0;
    ar         = '0;

    res_item         = res_r;
    res_item.next_pc = pc_r;
    res_item.flags   = flags_r;

    case (st_r)
      iic_pkg::S_CLEAR: begin
        clr_mode = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == RW'(ROWS - 1)) begin
          st_nxt = iic_pkg::S_IDLE;
        end
      end
      iic_pkg::S_IDLE: begin
        mem_ea    = {48'b0, q_item.word_address, 2'b00};
        mem_wdata = {32'b0, q_item.word_data};
        rf_raddr  = q_item.register_index;
        if (q_valid) begin
          q_pop   = 1'b1;
          res_nxt = '0;
          case (q_item.kind)
            iic_pkg::K_PRELOAD: begin
              // write the word straight into the banks
              if (q_item.pre_fits) begin
                mem_we = 1'b1;
              end else begin
                res_nxt.status = iic_pkg::ST_BADADDR;
              end
              st_nxt = iic_pkg::S_DONE;
            end
            iic_pkg::K_READ: st_nxt = iic_pkg::S_REGRD;
            iic_pkg::K_EXEC: st_nxt = iic_pkg::S_FETCH;
            default: begin
              res_nxt.status = iic_pkg::ST_BADENC;
              st_nxt         = iic_pkg::S_DONE;
            end
          endcase
        end
      end
      iic_pkg::S_REGRD: begin
        res_nxt.reg_value = rfval;
        st_nxt            = iic_pkg::S_DONE;
      end
      iic_pkg::S_FETCH: begin
        mem_ea = {pc_r[63:2], 2'b00};
        if (halted_r || (pc_r >= {47'b0, prog_words, 2'b00})) begin
          res_nxt.status = iic_pkg::ST_END;
          st_nxt         = iic_pkg::S_DONE;
        end else if ({pc_r[63:2], 2'b00} > LIM4) begin
          res_nxt.status = iic_pkg::ST_BADADDR;
          pc_nxt         = pc_p4;
          st_nxt         = iic_pkg::S_DONE;
        end else begin
          st_nxt = iic_pkg::S_FWAIT;
        end
      end
      iic_pkg::S_FWAIT: begin
        ir_nxt = mem_got[31:0];
        st_nxt = iic_pkg::S_DECODE;
      end
      iic_pkg::S_DECODE: begin
        rf_raddr = w[9:5];
        if (w == iic_pkg::HALT_WORD) begin
          halted_nxt     = 1'b1;
          pc_nxt         = pc_p4;
          res_nxt.status = iic_pkg::ST_END;
          st_nxt         = iic_pkg::S_DONE;
        end else begin
          st_nxt = iic_pkg::S_RDB;
        end
      end
      iic_pkg::S_RDB: begin
        ra_nxt   = rfval;
        rf_raddr = w[20:16];
        st_nxt   = iic_pkg::S_RDC;
      end
      iic_pkg::S_RDC: begin
        rb_nxt   = rfval;
        rf_raddr = (is_dpreg && w[28]) ? w[14:10] : w[4:0];
        st_nxt   = iic_pkg::S_RDW;
      end
      iic_pkg::S_RDW: begin
        rc_nxt = rfval;
        st_nxt = iic_pkg::S_SHIFT;
      end
      iic_pkg::S_SHIFT: begin
        opb_nxt  = iic_pkg::shift_val(rb_r, w[23:22], w[15:10], wide);
        // one adder forms the effective address and the written-back base
        base_sel = ld_lit ? pc_r : ra_r;
        if (ld_lit) begin
          off = {{43{w[23]}}, w[23:5], 2'b00};
        end else if (w[24]) begin
          off = nb8 ? {49'b0, w[21:10], 3'b000} : {50'b0, w[21:10], 2'b00};
        end else if (w[21]) begin
          off = rb_r;
        end else begin
          off = {{55{w[20]}}, w[20:12]};
        end
        sum       = base_sel + off;
        nbase_nxt = sum;
        ea_nxt    = (ld_wb && !w[11]) ? ra_r : sum;
        st_nxt    = (is_dpreg && w[28]) ? iic_pkg::S_MUL1 : iic_pkg::S_ALU;
      end
      iic_pkg::S_MUL1: begin
        p0_nxt = mul_p;
        st_nxt = iic_pkg::S_MUL2;
      end
      iic_pkg::S_MUL2: begin
        mul_b  = vbm[63:32];
        p1_nxt = mul_p[31:0];
        st_nxt = iic_pkg::S_MUL3;
      end
      iic_pkg::S_MUL3: begin
        mul_a     = va[63:32];
        cross_nxt = p1_r + mul_p[31:0];
        st_nxt    = iic_pkg::S_MULACC;
      end
      iic_pkg::S_MULACC: begin
        prod   = p0_r + {cross_r, 32'b0};
        val    = w[15] ? (rc_r - prod) : (rc_r + prod);
        wr_req = 1'b1;
        wr_idx = w[4:0];
        wr_val = val & mask;
        pc_nxt = pc_p4;
        st_nxt = iic_pkg::S_DONE;
      end
      iic_pkg::S_ALU: begin
        st_nxt = iic_pkg::S_DONE;
        if (is_dpimm) begin
          case (w[25:23])
            3'd2: begin
              imm = w[22] ? {40'b0, w[21:10], 12'b0} : {52'b0, w[21:10]};
              ar  = iic_pkg::add_flags(ra_r, imm, w[30], wide);
              if (w[29]) begin
                flags_nxt = ar.fl;
              end
              wr_req = 1'b1;
              wr_idx = w[4:0];
              wr_val = ar.val;
            end
            3'd5: begin
              piece = {48'b0, w[20:5]} << {w[22:21], 4'b0000};
              keep  = ~(64'h0000_0000_0000_FFFF << {w[22:21], 4'b0000});
              wr_idx = w[4:0];
              case (w[30:29])
                2'd0: begin
                  wr_req = 1'b1;
                  wr_val = ~piece & mask;
                end
                2'd2: begin
                  wr_req = 1'b1;
                  wr_val = piece & mask;
                end
                2'd3: begin
                  wr_req = 1'b1;
                  wr_val = ((rc_r & keep) | piece) & mask;
                end
                default: stat = iic_pkg::ST_BADENC;
              endcase
            end
            default: stat = iic_pkg::ST_BADENC;
          endcase
        end else if (is_dpreg) begin
          if (!wide && w[15]) begin
            stat = iic_pkg::ST_BADENC;
          end else if (w[24]) begin
            if ((w[23:22] == 2'd3) || w[21]) begin
              stat = iic_pkg::ST_BADENC;
            end else begin
              ar = iic_pkg::add_flags(va, opb_r, w[30], wide);
              if (w[29]) begin
                flags_nxt = ar.fl;
              end
              wr_req = 1'b1;
              wr_idx = w[4:0];
              wr_val = ar.val;
            end
          end else begin
            vb2 = w[21] ? (~opb_r & mask) : opb_r;
            case (w[30:29])
              2'd0: val = va & vb2;
              2'd1: val = va | vb2;
              2'd2: val = va ^ vb2;
              default: begin
                val       = va & vb2;
                flags_nxt = {(wide ? val[63] : val[31]), (val == 64'b0), 2'b00};
              end
            endcase
            wr_req = 1'b1;
            wr_idx = w[4:0];
            wr_val = val & mask;
          end
        end else if (is_ldst) begin
          if (ea_r > (nb8 ? LIM8 : LIM4)) begin
            stat = iic_pkg::ST_BADADDR;
          end else begin
            mem_ea    = ea_r;
            mem_n8    = nb8;
            mem_wdata = nb8 ? rc_r : (rc_r & iic_pkg::MASK32);
            if (ld_wb) begin
              // base goes back first; a load to the same register wins later
              wr_req = 1'b1;
              wr_idx = w[9:5];
              wr_val = nbase_r;
            end
            if (ld_isload) begin
              st_nxt = iic_pkg::S_MEMWAIT;
            end else begin
              mem_we                   = 1'b1;
              res_nxt.mem_written      = 1'b1;
              res_nxt.mem_byte_address = ea_r[15:0];
              res_nxt.mem_value        = mem_wdata;
              res_nxt.mem_wide         = nb8;
            end
          end
        end else if (is_br) begin
          case (w[31:26])
            iic_pkg::BR_IMM:  npc = pc_r + {{36{w[25]}}, w[25:0], 2'b00};
            iic_pkg::BR_REG:  npc = ra_r;
            iic_pkg::BR_COND: begin
              if (iic_pkg::cond_holds(w[3:0], flags_r)) begin
                npc = pc_r + {{43{w[23]}}, w[23:5], 2'b00};
              end
            end
            default: stat = iic_pkg::ST_BADENC;
          endcase
        end else begin
          stat = iic_pkg::ST_BADENC;
        end
        res_nxt.status = stat;
        if (st_nxt == iic_pkg::S_DONE) begin
          pc_nxt = (stat == iic_pkg::ST_DONE) ? npc : pc_p4;
        end
      end
      iic_pkg::S_MEMWAIT: begin
        wr_req = 1'b1;
        wr_idx = w[4:0];
        wr_val = nb8 ? mem_got : (mem_got & iic_pkg::MASK32);
        pc_nxt = pc_p4;
        st_nxt = iic_pkg::S_DONE;
      end
      iic_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_nxt = iic_pkg::S_IDLE;
        end
      end
      default: st_nxt = iic_pkg::S_IDLE;
    endcase

    // Register 31 drops writes and leaves no report.
    rf_we    = wr_req && (wr_idx != iic_pkg::ZERO_REG);
    rf_waddr = wr_idx;
    rf_wdata = wr_val;
    if (rf_we) begin
      res_nxt.reg_written = 1'b1;
      res_nxt.reg_dest    = wr_idx;
      res_nxt.reg_value   = wr_val;
    end
  end

  iic_ram #(
    .WIDTH(64),
    .DEPTH(32)
  ) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // Eight byte banks: byte k of an access lands in bank (ea + k) mod 8,
  // so any access of up to eight bytes touches each bank at most once.
  for (genvar j = 0; j < 8; j++) begin : g_bank
    logic [2:0]    off_j;
    logic [AW-1:0] byte_j;
    logic [RW-1:0] row_j;
    logic          we_j;
    logic [7:0]    wd_j;

    always_comb begin
      off_j  = 3'(j) - mem_ea[2:0];
      byte_j = mem_ea[AW-1:0] + AW'(off_j);
      if (clr_mode) begin
        row_j = clr_r;
        we_j  = 1'b1;
        wd_j  = 8'b0;
      end else begin
        row_j = byte_j[AW-1:3];
        we_j  = mem_we && (off_j[2] == 1'b0 || mem_n8);
        wd_j  = mem_wdata[{off_j, 3'b000} +: 8];
      end
    end

    iic_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_bank (
      .clk   (clk),
      .we    (we_j),
      .waddr (row_j),
      .wdata (wd_j),
      .raddr (row_j),
      .rdata (bank_rd[j])
    );
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mem_got[8*k +: 8] = bank_rd[3'(k) + mem_lo_r];
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    ir_r      <= ir_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    rc_r      <= rc_nxt;
    opb_r     <= opb_nxt;
    ea_r      <= ea_nxt;
    nbase_r   <= nbase_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    cross_r   <= cross_nxt;
    mem_lo_r  <= mem_ea[2:0];
    rf_zero_r <= ~rf_vld_r[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= iic_pkg::S_CLEAR;
      clr_r    <= '0;
      pc_r     <= 64'b0;
      flags_r  <= iic_pkg::FLAGS_RESET;
      halted_r <= 1'b0;
      rf_vld_r <= 32'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      pc_r     <= pc_nxt;
      flags_r  <= flags_nxt;
      halted_r <= halted_nxt;
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
    end
  end

endmodule

// ===== design/integer_instruction_core.sv =====
// Top level of the integer instruction core: config register, front end,
// back end and output register. Depends on iic_pkg, iic_front, iic_back.
//
// Usage:
//   Input beats (in_valid/in_ready/in_data) carry one of: a 32-bit word
//   preload, an execute-one-instruction request, or a register read.
//   Each accepted beat yields exactly one result beat on out_valid/out_ready
//   with status, next pc, flags and the register and memory writes made.
//   cfg_we/cfg_wdata set the program length in words; write it while idle.
// Queueing:
//   A two-entry queue sits behind the input, so beats are taken while the
//   back end works. The back end handles one item at a time; instructions
//   take longer than preloads, bad opcodes and register reads because of
//   the serial register-file reads, and a multiply-add also shares the
//   single 32x32 multiplier. Every result then passes the output register.
// Reset:
//   rst_n is synchronous. After it the registers read zero, flags are Z,
//   pc is zero, and the byte memory is swept to zero, one 8-byte row per
//   cycle over all MEM_BYTES/8 rows; no beat is executed during the sweep.
// Stalls:
//   When out_ready is low the result holds in the output register, the
//   back end waits with the next result and the queue fills, then in_ready
//   drops.
module integer_instruction_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iic_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iic_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata
);

  logic [14:0]        prog_words_r;
  logic               q_valid;
  logic               q_pop;
  iic_pkg::q_item_t   q_item;
  logic               res_valid;
  logic               res_ready;
  iic_pkg::out_item_t res_item;
  logic               out_valid_r;
  iic_pkg::out_item_t out_data_r;

  // Program length register; hold until the next write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_words_r <= 15'd0;
    end else if (cfg_we) begin
      prog_words_r <= cfg_wdata;
    end
  end

  iic_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  iic_back #(
    .MEM_BYTES(MEM_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .prog_words (prog_words_r),
    .res_valid  (res_valid),
    .res_item   (res_item),
    .res_ready  (res_ready)
  );

  // Output register: advance when empty or when the current beat is taken.
  assign res_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_integer_instruction_core.sv =====
// Testbench for integer_instruction_core: random and directed item streams,
// checked against an in-bench model of the core. Depends on iic_pkg and the RTL.
`timescale 1ns / 100ps

module tb_integer_instruction_core;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;     // item opcode with no meaning
  localparam logic [3:0]  GRP_LDST_A  = 4'h6;
  localparam logic [3:0]  GRP_LDST_B  = 4'h7;
  localparam logic [3:0]  GRP_LDST_C  = 4'hC;
  localparam logic [5:0]  BR_BAD_A    = 6'h25;    // branch group, unknown form
  localparam logic [5:0]  BR_BAD_B    = 6'h0D;
  localparam logic [63:0] MEM_SIZE    = 64'd65536;
  localparam logic [63:0] PC_CEILING  = 64'hD000; // steer the pc back below this
  localparam logic [63:0] BR_SAFE_TOP = 64'hE000;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          ITEM_TARGET = 445;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  iic_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  iic_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [14:0]        cfg_wdata = '0;

  integer_instruction_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the core's architectural state.
  logic [63:0] xreg [31];
  logic [3:0]  nzcv;
  logic [63:0] pc;
  logic        halted;
  logic [7:0]  dmem [65536];
  logic [14:0] prog_words;

  // What the current instruction wrote, for the result beat.
  logic        wb_reg;
  logic [4:0]  wb_dst;
  logic [63:0] wb_val;
  logic        st_mem;
  logic [15:0] st_addr;
  logic [63:0] st_val;
  logic        st_wide;

  iic_pkg::in_item_t  item_q [$];     // beats waiting for the driver
  iic_pkg::out_item_t result_q [$];   // predicted result beats, oldest first
  int        fails = 0;
  int        n_items = 0;
  int        cycles = 0;
  logic      quiet = 1'b0;   // no idling on either side while set

  function automatic logic [63:0] get_reg(input logic [4:0] i);
    return (i == iic_pkg::ZERO_REG) ? 64'd0 : xreg[i];
  endfunction

  function automatic void put_reg(input logic [4:0] i, input logic [63:0] v);
    if (i != iic_pkg::ZERO_REG) begin
      xreg[i] = v;
      wb_reg  = 1'b1;
      wb_dst  = i;
      wb_val  = v;
    end
  endfunction

  function automatic logic in_mem(input logic [63:0] a, input int n);
    return a <= MEM_SIZE - 64'(n);
  endfunction

  function automatic logic [63:0] mem_load(input logic [63:0] a, input int n);
    logic [63:0] v;
    v = '0;
    for (int k = n - 1; k >= 0; k--) v = (v << 8) | 64'(dmem[a[15:0] + 16'(k)]);
    return v;
  endfunction

  function automatic void mem_store(input logic [63:0] a, input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) dmem[a[15:0] + 16'(k)] = v[8*k +: 8];
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    v = v & m;
    return v[bits-1] ? (v | ~m) : v;
  endfunction

  function automatic logic [63:0] shift_operand(input logic [63:0] v, input logic [1:0] kind,
                                                input logic [5:0] amt, input logic wide);
    logic [63:0] m;
    logic [63:0] r;
    int          w;
    m = wide ? '1 : iic_pkg::MASK32;
    w = wide ? 64 : 32;
    v = v & m;
    if (amt == 0) return v;
    case (kind)
      2'd0: r = v << amt;
      2'd1: r = v >> amt;
      2'd2: begin
        r = v >> amt;
        if (v[w-1]) r = r | (m & ~(m >> amt));
      end
      default: r = (v >> amt) | (v << (w - int'(amt)));
    endcase
    return r & m;
  endfunction

  function automatic logic [63:0] add_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic sub, input logic wide,
                                          output logic [3:0] fl);
    logic [63:0] m;
    logic [64:0] s;
    logic [63:0] r;
    logic        c;
    logic        v;
    logic        n;
    m = wide ? '1 : iic_pkg::MASK32;
    a = a & m;
    b = b & m;
    if (sub) b = ~b & m;
    s = {1'b0, a} + {1'b0, b} + 65'(sub);
    if (wide) begin
      r = s[63:0];
      c = s[64];
      v = a[63] ^ r[63] ? (b[63] ^ r[63]) : 1'b0;
      n = r[63];
    end else begin
      r = {32'd0, s[31:0]};
      c = s[32];
      v = a[31] ^ r[31] ? (b[31] ^ r[31]) : 1'b0;
      n = r[31];
    end
    fl = {n, r == 64'd0, c, v};
    return r;
  endfunction

  function automatic logic cond_true(input logic [3:0] c);
    logic t;
    case (c[3:1])
      3'd0: t = nzcv[2];
      3'd1: t = nzcv[1];
      3'd2: t = nzcv[3];
      3'd3: t = nzcv[0];
      3'd4: t = nzcv[1] & ~nzcv[2];
      3'd5: t = nzcv[3] == nzcv[0];
      3'd6: t = (nzcv[3] == nzcv[0]) & ~nzcv[2];
      default: t = 1'b1;
    endcase
    // Condition 15 stays "always", like 14.
    if (c[0] && c != 4'hF) t = ~t;
    return t;
  endfunction

  function automatic logic [1:0] exec_dp_imm(input logic [31:0] w);
    logic [63:0] m;
    logic [63:0] val;
    logic [63:0] im;
    logic [63:0] piece;
    logic [3:0]  fl;
    int          pos;
    m = w[31] ? '1 : iic_pkg::MASK32;
    case (w[25:23])
      3'd2: begin
        im = {52'd0, w[21:10]};
        if (w[22]) im = im << 12;
        val = add_sub(get_reg(w[9:5]), im, w[30], w[31], fl);
        if (w[29]) nzcv = fl;
        put_reg(w[4:0], val);
        return iic_pkg::ST_DONE;
      end
      3'd5: begin
        pos   = int'(w[22:21]) * 16;
        piece = {48'd0, w[20:5]} << pos;
        case (w[30:29])
          2'd0: val = ~piece;
          2'd2: val = piece;
          2'd3: val = (get_reg(w[4:0]) & ~(64'hFFFF << pos)) | piece;
          default: return iic_pkg::ST_BADENC;
        endcase
        // A 32-bit move loses anything shifted above bit 31.
        put_reg(w[4:0], val & m);
        return iic_pkg::ST_DONE;
      end
      default: return iic_pkg::ST_BADENC;
    endcase
  endfunction

  function automatic logic [1:0] exec_dp_reg(input logic [31:0] w);
    logic        wide;
    logic [63:0] m;
    logic [63:0] va;
    logic [63:0] vb;
    logic [63:0] val;
    logic [63:0] prod;
    logic [3:0]  fl;
    wide = w[31];
    m    = wide ? '1 : iic_pkg::MASK32;
    va   = get_reg(w[9:5]) & m;
    vb   = get_reg(w[20:16]);
    if (w[28]) begin
      prod = va * (vb & m);
      val  = w[15] ? get_reg(w[14:10]) - prod : get_reg(w[14:10]) + prod;
      put_reg(w[4:0], val & m);
      return iic_pkg::ST_DONE;
    end
    if (!wide && w[15]) return iic_pkg::ST_BADENC;
    vb = shift_operand(vb, w[23:22], w[15:10], wide);
    if (w[24]) begin
      if (w[23:22] == 2'd3 || w[21]) return iic_pkg::ST_BADENC;
      val = add_sub(va, vb, w[30], wide, fl);
      if (w[29]) nzcv = fl;
    end else begin
      if (w[21]) vb = ~vb & m;
      case (w[30:29])
        2'd0: val = va & vb;
        2'd1: val = va | vb;
        2'd2: val = va ^ vb;
        default: begin
          val  = va & vb;
          nzcv = {wide ? val[63] : val[31], val == 64'd0, 2'b00};
        end
      endcase
    end
    put_reg(w[4:0], val & m);
    return iic_pkg::ST_DONE;
  endfunction

  function automatic logic [1:0] exec_ld_st(input logic [31:0] w);
    logic        wide;
    int          nb;
    logic        load;
    logic        wback;
    logic [63:0] ea;
    logic [63:0] nbase;
    logic [63:0] sdata;
    logic [63:0] got;
    wide  = w[30];
    nb    = wide ? 8 : 4;
    load  = 1'b1;
    wback = 1'b0;
    nbase = '0;
    sdata = get_reg(w[4:0]);
    if (!w[29]) begin
      ea = pc + (sign_ext({45'd0, w[23:5]}, 19) << 2);
    end else begin
      ea   = get_reg(w[9:5]);
      load = w[22];
      if (w[24]) begin
        ea = ea + 64'(w[21:10]) * 64'(nb);
      end else if (w[21]) begin
        ea = ea + get_reg(w[20:16]);
      end else begin
        nbase = ea + sign_ext({55'd0, w[20:12]}, 9);
        if (w[11]) ea = nbase;
        wback = 1'b1;
      end
    end
    if (!in_mem(ea, nb)) return iic_pkg::ST_BADADDR;
    got = mem_load(ea, nb);
    if (!load) begin
      if (!wide) sdata = sdata & iic_pkg::MASK32;
      mem_store(ea, sdata, nb);
      st_mem  = 1'b1;
      st_addr = ea[15:0];
      st_val  = sdata;
      st_wide = wide;
    end
    // Base first, so a load into the base register wins.
    if (wback) put_reg(w[9:5], nbase);
    if (load) put_reg(w[4:0], got);
    return iic_pkg::ST_DONE;
  endfunction

  function automatic logic [63:0] branch_dest(input logic [31:0] w);
    case (w[31:26])
      iic_pkg::BR_IMM:  return pc + (sign_ext({38'd0, w[25:0]}, 26) << 2);
      iic_pkg::BR_REG:  return get_reg(w[9:5]);
      iic_pkg::BR_COND: return cond_true(w[3:0]) ? pc + (sign_ext({45'd0, w[23:5]}, 19) << 2)
                                                 : pc + 64'd4;
      default: return pc + 64'd4;
    endcase
  endfunction

  function automatic logic [1:0] exec_instr();
    logic [63:0] fa;
    logic [63:0] npc;
    logic [31:0] w;
    logic [1:0]  st;
    if (halted || pc >= (64'(prog_words) << 2)) return iic_pkg::ST_END;
    fa = pc & ~64'd3;
    if (!in_mem(fa, 4)) begin
      pc = pc + 64'd4;
      return iic_pkg::ST_BADADDR;
    end
    w = mem_load(fa, 4);
    if (w == iic_pkg::HALT_WORD) begin
      halted = 1'b1;
      pc     = pc + 64'd4;
      return iic_pkg::ST_END;
    end
    npc = pc + 64'd4;
    case (w[28:25])
      4'h8, 4'h9: st = exec_dp_imm(w);
      4'h5, 4'hD: st = exec_dp_reg(w);
      GRP_LDST_A, GRP_LDST_B, GRP_LDST_C: st = exec_ld_st(w);
      4'hA, 4'hB: begin
        if (w[31:26] == iic_pkg::BR_IMM || w[31:26] == iic_pkg::BR_REG ||
            w[31:26] == iic_pkg::BR_COND) begin
          npc = branch_dest(w);
          st  = iic_pkg::ST_DONE;
        end else begin
          st = iic_pkg::ST_BADENC;
        end
      end
      default: st = iic_pkg::ST_BADENC;
    endcase
    pc = (st == iic_pkg::ST_DONE) ? npc : pc + 64'd4;
    return st;
  endfunction

  function automatic iic_pkg::out_item_t predict_beat(input iic_pkg::in_item_t it);
    iic_pkg::out_item_t o;
    logic [63:0]        a;
    logic [63:0]        readv;
    logic [1:0]         st;
    wb_reg = 1'b0; wb_dst = '0; wb_val = '0;
    st_mem = 1'b0; st_addr = '0; st_val = '0; st_wide = 1'b0;
    st     = iic_pkg::ST_DONE;
    readv  = '0;
    case (it.opcode)
      iic_pkg::OP_PRELOAD: begin
        a = 64'(it.word_address) << 2;
        if (in_mem(a, 4)) mem_store(a, {32'd0, it.word_data}, 4);
        else st = iic_pkg::ST_BADADDR;
      end
      iic_pkg::OP_EXEC: st = exec_instr();
      iic_pkg::OP_READ: readv = get_reg(it.register_index);
      default: st = iic_pkg::ST_BADENC;
    endcase
    o.status           = st;
    o.next_pc          = pc;
    o.flags            = nzcv;
    o.reg_written      = wb_reg;
    o.reg_dest         = wb_dst;
    o.reg_value        = wb_reg ? wb_val : readv;
    o.mem_written      = st_mem;
    o.mem_byte_address = st_addr;
    o.mem_value        = st_val;
    o.mem_wide         = st_wide;
    return o;
  endfunction

  // Predict first, then hand the beat to the driver.
  task automatic send(input logic [1:0] op, input logic [13:0] wa, input logic [31:0] wd,
                      input logic [4:0] ri);
    iic_pkg::in_item_t it;
    it.opcode         = op;
    it.word_address   = wa;
    it.word_data      = wd;
    it.register_index = ri;
    result_q.push_back(predict_beat(it));
    item_q.push_back(it);
    n_items++;
  endtask

  // Place an instruction at the pc and step it.
  task automatic run_word(input logic [31:0] w);
    send(iic_pkg::OP_PRELOAD, pc[15:2], w, 5'($urandom));
    send(iic_pkg::OP_EXEC, 14'($urandom), 32'($urandom), 5'($urandom));
  endtask

  task automatic set_zx(input logic [4:0] r, input logic [15:0] v);
    run_word({1'b1, 2'b10, 6'b100101, 2'b00, v, r});
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_prog_words(input logic [14:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    prog_words = v;
    quiet     <= ($urandom_range(0, 3) == 0);
  endtask

  task automatic random_step();
    logic [31:0] w;
    logic [63:0] tgt;
    int          pick;
    // Drift toward the top of memory: branch back to a low address.
    if (pc >= PC_CEILING) begin
      tgt = ((64'($urandom_range(0, 16'h3FFF))) & ~64'd3) | (pc & 64'd3);
      tgt = tgt - pc;
      run_word({iic_pkg::BR_IMM, tgt[27:2]});
      return;
    end
    pick = $urandom_range(0, 99);
    w    = $urandom;
    if (pick < 8) begin
      send(iic_pkg::OP_READ, 14'($urandom), 32'($urandom), 5'($urandom));
    end else if (pick < 12) begin
      send(iic_pkg::OP_PRELOAD, 14'($urandom), 32'($urandom), 5'($urandom));
    end else if (pick < 14) begin
      send(OP_UNUSED, 14'($urandom), 32'($urandom), 5'($urandom));
    end else if (pick < 17) begin
      // Step whatever sits at the pc, unless it could steer the pc away.
      w = mem_load(pc & ~64'd3, 4);
      if (w[28:26] != 3'b101 && w != iic_pkg::HALT_WORD)
        send(iic_pkg::OP_EXEC, 14'($urandom), 32'($urandom), 5'($urandom));
    end else if (pick < 30) begin
      w[28:23] = 6'b100010;
      run_word(w);
    end else if (pick < 42) begin
      w[28:23] = 6'b100101;
      run_word(w);
    end else if (pick < 52) begin
      w[28:24] = 5'b01010;
      if (!w[31] && $urandom_range(0, 3) != 0) w[15] = 1'b0;
      run_word(w);
    end else if (pick < 62) begin
      w[28:24] = 5'b01011;
      if ($urandom_range(0, 3) != 0) begin
        w[21] = 1'b0;
        if (w[23:22] == 2'd3) w[23] = 1'b0;
        if (!w[31]) w[15] = 1'b0;
      end
      run_word(w);
    end else if (pick < 70) begin
      w[28:25] = 4'hD;
      run_word(w);
    end else if (pick < 86) begin
      case ($urandom_range(0, 2))
        0: w[28:25] = GRP_LDST_A;
        1: w[28:25] = GRP_LDST_B;
        default: w[28:25] = GRP_LDST_C;
      endcase
      if ($urandom_range(0, 7) != 0) w[29] = 1'b1;
      if (!w[29]) begin
        w[23:5] = 19'($urandom_range(0, 128)) - 19'd64;
      end else begin
        if ($urandom_range(0, 3) != 0) set_zx(w[9:5], 16'($urandom_range(0, 16'hFFF0)));
        if (!w[24] && w[21] && $urandom_range(0, 1) == 1)
          set_zx(w[20:16], 16'($urandom_range(0, 16'h0FFF)));
      end
      run_word(w);
    end else if (pick < 96) begin
      case ($urandom_range(0, 3))
        0: w[31:26] = iic_pkg::BR_IMM;
        1: begin
          w[31:26] = iic_pkg::BR_REG;
          if ($urandom_range(0, 1) == 1) set_zx(w[9:5], 16'($urandom_range(0, 16'hDFFF)));
        end
        2: begin
          w[31:26] = iic_pkg::BR_COND;
          w[23:5]  = 19'($urandom_range(0, 128)) - 19'd64;
        end
        default: w[31:26] = $urandom_range(0, 1) ? BR_BAD_A : BR_BAD_B;
      endcase
      if (w[31:26] == iic_pkg::BR_IMM) w[25:0] = 26'($urandom_range(0, 128)) - 26'd64;
      if (branch_dest(w) >= BR_SAFE_TOP) w = {iic_pkg::BR_IMM, 26'd1};
      run_word(w);
    end else begin
      // Groups that hold no instruction at all.
      w[28:25] = 4'($urandom_range(0, 4));
      run_word(w);
    end
  endtask

  // Sender: hold a beat until taken, then idle for the drawn gap.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (item_q.size() != 0) begin
      in_data  <= item_q.pop_front();
      in_valid <= 1'b1;
      in_gap   <= quiet ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: check each result beat, then stall for the drawn count.
  int out_stall;
  int n_stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          if (fails < 10) $display("ERROR: result beat with nothing expected: %p", out_data);
          fails++;
        end else if (out_data !== result_q[0]) begin
          if (fails < 10) begin
            $display("ERROR: result mismatch");
            $display("  expected %p", result_q[0]);
            $display("  actual   %p", out_data);
          end
          fails++;
          void'(result_q.pop_front());
        end else begin
          void'(result_q.pop_front());
        end
        n_stall = quiet ? 0 : $urandom_range(0, 5);
        out_ready <= (n_stall == 0);
        out_stall <= n_stall;
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        if (out_stall == 1) out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 31; i++) xreg[i] = '0;
    for (int i = 0; i < 65536; i++) dmem[i] = '0;
    nzcv       = iic_pkg::FLAGS_RESET;
    pc         = '0;
    halted     = 1'b0;
    prog_words = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state, an empty program and the edges of the preload window.
    send(iic_pkg::OP_READ, 14'd0, 32'd0, 5'd0);
    send(iic_pkg::OP_READ, 14'h3FFF, 32'hFFFF_FFFF, iic_pkg::ZERO_REG);
    send(iic_pkg::OP_EXEC, 14'd0, 32'd0, 5'd0);
    send(OP_UNUSED, 14'h3FFF, 32'hFFFF_FFFF, 5'd31);
    send(iic_pkg::OP_PRELOAD, 14'h3FFF, 32'hFFFF_FFFF, 5'd0);
    send(iic_pkg::OP_PRELOAD, 14'd0, 32'd0, 5'd0);
    write_prog_words(15'd16384);

    run_word({1'b1, 2'b10, 6'b100101, 2'b11, 16'hFFFF, 5'd1});           // movz top half
    run_word({1'b1, 2'b00, 6'b100101, 2'b00, 16'h0000, 5'd2});           // movn, all ones
    run_word({1'b0, 2'b11, 6'b100101, 2'b10, 16'hABCD, 5'd3});           // movk cut to 32 bits
    run_word({1'b1, 1'b0, 1'b1, 6'b100010, 1'b0, 12'd1, 5'd2, 5'd4});    // adds: carry, zero
    set_zx(5'd6, 16'hFFFF);
    run_word({1'b0, 2'b11, 6'b100101, 2'b01, 16'h7FFF, 5'd6});
    run_word({1'b0, 1'b0, 1'b1, 6'b100010, 1'b0, 12'd1, 5'd6, 5'd5});    // 32-bit overflow
    run_word({1'b1, 1'b1, 1'b1, 6'b100010, 1'b0, 12'd1, iic_pkg::ZERO_REG,
              5'd7});                                                     // subs below zero
    run_word({1'b1, 2'b11, 5'b01010, 2'b00, 1'b0, 5'd1, 6'd0, 5'd2, 5'd8});
    run_word({1'b1, 2'b10, 5'b01010, 2'b11, 1'b1, 5'd1, 6'd7, 5'd2, 5'd9});
    run_word({1'b1, 2'b00, 5'b11011, 3'b000, 5'd2, 1'b1, 5'd1, 5'd6, 5'd10});
    run_word({1'b0, 2'b00, 5'b01011, 2'b00, 1'b0, 5'd1, 6'd40, 5'd2, 5'd16}); // shift too wide
    run_word({1'b1, 1'b1, 1'b1, GRP_LDST_C, 1'b1, 1'b0, 1'b0, 12'd1, iic_pkg::ZERO_REG,
              5'd2});
    set_zx(5'd12, 16'd5);
    run_word({1'b1, 1'b1, 1'b1, GRP_LDST_C, 1'b0, 1'b0, 1'b1, 1'b1, 5'd12, 6'd0,
              iic_pkg::ZERO_REG, 5'd13});                                 // unaligned load
    set_zx(5'd14, 16'h0100);
    run_word({1'b1, 1'b1, 1'b1, GRP_LDST_C, 1'b0, 1'b0, 1'b1, 1'b0, 9'h1F8, 1'b1, 1'b0,
              5'd14, 5'd14});                                             // pre-index, base = dest
    run_word({1'b0, 1'b0, 1'b1, GRP_LDST_C, 1'b0, 1'b0, 1'b0, 1'b0, 9'd4, 1'b0, 1'b0,
              5'd12, 5'd2});                                              // post-index store
    run_word({1'b1, 1'b1, 1'b1, GRP_LDST_C, 1'b1, 1'b0, 1'b1, 12'd0, 5'd2, 5'd15}); // off the end
    run_word({iic_pkg::BR_COND, 2'b00, 19'd2, 1'b0, 4'hF});
    run_word(32'd0);
    run_word({iic_pkg::BR_REG, 16'd0, 5'd12, 5'd0});                      // to an unaligned pc
    run_word({iic_pkg::BR_IMM, 26'h3FF_FFFF});

    // Random phases, each under its own program length.
    while (n_items < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: write_prog_words(15'h7FFF);
        1: write_prog_words(15'($urandom_range(1, 16384)));
        2: write_prog_words(15'($urandom_range(0, 64)));
        default: write_prog_words(15'd16384);
      endcase
      for (int k = 0; k < 80 && n_items < ITEM_TARGET; k++) random_step();
    end

    // Halt last: nothing steps after it.
    write_prog_words(15'd16384);
    run_word(iic_pkg::HALT_WORD);
    send(iic_pkg::OP_EXEC, 14'd0, 32'd0, 5'd0);
    send(iic_pkg::OP_READ, 14'd0, 32'd0, 5'd2);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fails == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
